[hw/rtl/wavhp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wavhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [15:0] FORMAT_PCM     = 16'd1;
  localparam logic [15:0] BITS_SUPPORTED = 16'd16;
  localparam logic [31:0] FMT_MIN_LENGTH = 32'd16;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_TAG     = 3'd1,
    ST_TRUNCATED   = 3'd2,
    ST_BAD_FORMAT  = 3'd3,
    ST_EMPTY_DATA  = 3'd4
  } wavhp_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } wavhp_beat_t;

  typedef struct packed {
    wavhp_status_e status;
    logic [15:0]   channel_count;
    logic [31:0]   sample_rate;
    logic [15:0]   sample_bits;
    logic [31:0]   data_offset;
    logic [31:0]   data_length;
  } wavhp_result_t;

endpackage

`default_nettype wire

[hw/rtl/wavhp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface wavhp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [15:0] sample_bits;
  logic [31:0] data_offset;
  logic [31:0] data_length;

  modport source (output valid, output status, output channel_count, output sample_rate,
                  output sample_bits, output data_offset, output data_length,
                  input ready);
  modport sink   (input valid, input status, input channel_count, input sample_rate,
                  input sample_bits, input data_offset, input data_length,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/wav_header_parser_top.sv]
// Result: the byte that completes the data chunk header, a bad tag, or the last byte of
// the file is held in the input register; its result then enters the result register.
// Throughput: one byte per cycle, set by the single pass of the parse logic between the
// input register and the result register; stalls only while a result waits unaccepted.
// Reset: rst_ni clears the stages and returns the parser to idle, waiting for a first byte.
`timescale 1ns / 1ps
`default_nettype none

module wav_header_parser_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  wavhp_in_if.sink     in_i,
  wavhp_out_if.source  out_o
);
  import wavhp_pkg::*;

  logic          in_valid_q;
  wavhp_beat_t   in_beat_q;
  logic          out_valid_q;
  wavhp_result_t out_res_q;
  logic          advance;
  logic          emit;
  wavhp_result_t result;

  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_beat_q.data_byte  <= in_i.data_byte;
      in_beat_q.first_byte <= in_i.first_byte;
      in_beat_q.last_byte  <= in_i.last_byte;
    end
    if (advance && emit) begin
      out_res_q <= result;
    end
  end

  wavhp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .beat_i   (in_beat_q),
    .emit_o   (emit),
    .result_o (result)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_res_q.status;
  assign out_o.channel_count = out_res_q.channel_count;
  assign out_o.sample_rate   = out_res_q.sample_rate;
  assign out_o.sample_bits   = out_res_q.sample_bits;
  assign out_o.data_offset   = out_res_q.data_offset;
  assign out_o.data_length   = out_res_q.data_length;

endmodule

`default_nettype wire

[hw/rtl/wavhp_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module wavhp_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  wavhp_pkg::wavhp_beat_t   beat_i,
  output logic                    emit_o,
  output wavhp_pkg::wavhp_result_t result_o
);
  import wavhp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RIFF_TAG  = 4'd1,
    PH_RIFF_SIZE = 4'd2,
    PH_WAVE_TAG  = 4'd3,
    PH_CHUNK_HDR = 4'd4,
    PH_FMT_BODY  = 4'd5,
    PH_SKIP      = 4'd6,
    PH_DONE      = 4'd7
  } phase_e;

  phase_e      phase_q, phase_d, phase_c;
  logic [4:0]  idx_q, idx_d, idx_c, idx_inc;
  logic [31:0] tag_q, tag_d, tag_c, tag_shifted;
  logic [31:0] len_q, len_d, len_c, len_merged;
  logic [31:0] skip_q, skip_d, skip_c, skip_dec;
  logic [31:0] pos_q, pos_d, pos_c;
  logic [15:0] code_q, code_d, code_c;
  logic [15:0] chan_q, chan_d, chan_c;
  logic [31:0] rate_q, rate_d, rate_c;
  logic [15:0] bits_q, bits_d, bits_c;
  logic        ok_q, ok_d, ok_c;
  logic        restart;
  logic        emit;
  wavhp_status_e status;
  logic [31:0] out_offset;
  logic [31:0] out_length;
  logic [7:0]  b;

  assign b       = beat_i.data_byte;
  assign restart = step_i && beat_i.first_byte;

  always_comb begin
    phase_c = restart ? PH_RIFF_TAG : phase_q;
    idx_c   = restart ? 5'd0 : idx_q;
    tag_c   = restart ? 32'd0 : tag_q;
    len_c   = restart ? 32'd0 : len_q;
    skip_c  = restart ? 32'd0 : skip_q;
    pos_c   = restart ? 32'd0 : pos_q;
    code_c  = restart ? 16'd0 : code_q;
    chan_c  = restart ? 16'd1 : chan_q;
    rate_c  = restart ? 32'd0 : rate_q;
    bits_c  = restart ? 16'd16 : bits_q;
    ok_c    = restart ? 1'b0 : ok_q;

    tag_shifted = {tag_c[23:0], b};
    idx_inc     = idx_c + 5'd1;
    skip_dec    = skip_c - 32'd1;

    len_merged = len_c;
    unique case (idx_c[1:0])
      2'd0: len_merged[7:0]   = len_c[7:0]   | b;
      2'd1: len_merged[15:8]  = len_c[15:8]  | b;
      2'd2: len_merged[23:16] = len_c[23:16] | b;
      2'd3: len_merged[31:24] = len_c[31:24] | b;
      default: len_merged = len_c;
    endcase

    phase_d = phase_c;
    idx_d   = idx_c;
    tag_d   = tag_c;
    len_d   = len_c;
    skip_d  = skip_c;
    pos_d   = pos_c;
    code_d  = code_c;
    chan_d  = chan_c;
    rate_d  = rate_c;
    bits_d  = bits_c;
    ok_d    = ok_c;

    emit       = 1'b0;
    status     = ST_OK;
    out_offset = 32'd0;
    out_length = 32'd0;

    if (step_i && phase_c != PH_IDLE && phase_c != PH_DONE) begin
      pos_d = pos_c + 32'd1;
      unique case (phase_c)
        PH_RIFF_TAG, PH_WAVE_TAG: begin
          tag_d = tag_shifted;
          if (idx_c >= 5'd3) begin
            if (tag_shifted != ((phase_c == PH_RIFF_TAG) ? TAG_RIFF : TAG_WAVE)) begin
              emit   = 1'b1;
              status = ST_BAD_TAG;
            end else begin
              idx_d   = 5'd0;
              phase_d = (phase_c == PH_RIFF_TAG) ? PH_RIFF_SIZE : PH_CHUNK_HDR;
            end
          end else begin
            idx_d = idx_inc;
          end
        end
        PH_RIFF_SIZE: begin
          if (idx_c >= 5'd3) begin
            idx_d   = 5'd0;
            phase_d = PH_WAVE_TAG;
          end else begin
            idx_d = idx_inc;
          end
        end
        PH_CHUNK_HDR: begin
          if (idx_c < 5'd4) begin
            tag_d = tag_shifted;
            if (idx_c == 5'd0) begin
              len_d = 32'd0;
            end
            idx_d = idx_inc;
          end else begin
            len_d = len_merged;
            if (idx_c < 5'd7) begin
              idx_d = idx_inc;
            end else if (tag_c == TAG_DATA) begin
              emit       = 1'b1;
              out_offset = pos_d;
              out_length = len_merged;
              if (!ok_c) begin
                status = ST_BAD_FORMAT;
              end else if (len_merged == 32'd0) begin
                status = ST_EMPTY_DATA;
              end else begin
                status = ST_OK;
              end
            end else if (tag_c == TAG_FMT && len_merged >= FMT_MIN_LENGTH) begin
              skip_d  = len_merged - FMT_MIN_LENGTH;
              idx_d   = 5'd0;
              phase_d = PH_FMT_BODY;
            end else begin
              if (tag_c == TAG_FMT) begin
                ok_d = 1'b0;
              end
              skip_d  = len_merged;
              idx_d   = 5'd0;
              phase_d = (len_merged != 32'd0) ? PH_SKIP : PH_CHUNK_HDR;
            end
          end
        end
        PH_FMT_BODY: begin
          unique case (idx_c)
            5'd0:    code_d[7:0]   = b;
            5'd1:    code_d[15:8]  = b;
            5'd2:    chan_d[7:0]   = b;
            5'd3:    chan_d[15:8]  = b;
            5'd4:    rate_d[7:0]   = b;
            5'd5:    rate_d[15:8]  = b;
            5'd6:    rate_d[23:16] = b;
            5'd7:    rate_d[31:24] = b;
            5'd14:   bits_d[7:0]   = b;
            5'd15:   bits_d[15:8]  = b;
            default: code_d = code_c;
          endcase
          if (idx_c >= 5'd15) begin
            ok_d    = (code_d == FORMAT_PCM) && (bits_d == BITS_SUPPORTED) &&
                      (chan_d == 16'd1 || chan_d == 16'd2);
            idx_d   = 5'd0;
            phase_d = (skip_c != 32'd0) ? PH_SKIP : PH_CHUNK_HDR;
          end else begin
            idx_d = idx_inc;
          end
        end
        PH_SKIP: begin
          if (skip_c != 32'd0) begin
            skip_d = skip_dec;
          end
          if (skip_c == 32'd0 || skip_dec == 32'd0) begin
            idx_d   = 5'd0;
            phase_d = PH_CHUNK_HDR;
          end
        end
        default: phase_d = phase_c;
      endcase

      if (!emit && beat_i.last_byte) begin
        emit   = 1'b1;
        status = ST_TRUNCATED;
      end
      if (emit) begin
        phase_d = PH_DONE;
      end
    end
  end

  assign emit_o                 = emit;
  assign result_o.status        = status;
  assign result_o.channel_count = chan_d;
  assign result_o.sample_rate   = rate_d;
  assign result_o.sample_bits   = bits_d;
  assign result_o.data_offset   = out_offset;
  assign result_o.data_length   = out_length;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= 5'd0;
      tag_q   <= 32'd0;
      len_q   <= 32'd0;
      skip_q  <= 32'd0;
      pos_q   <= 32'd0;
      code_q  <= 16'd0;
      chan_q  <= 16'd1;
      rate_q  <= 32'd0;
      bits_q  <= 16'd16;
      ok_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      pos_q   <= pos_d;
      code_q  <= code_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      ok_q    <= ok_d;
    end
  end

  a_emit_enters_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit |=> phase_q == PH_DONE)
    else $error("parse not closed after result");

  a_ok_needs_format: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit && status == ST_OK |-> ok_c && out_length != 32'd0)
    else $error("ok result without supported format or data");

  a_done_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_DONE && !beat_i.first_byte |-> !emit ##1 $stable(pos_q))
    else $error("activity after result");

  a_hdr_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CHUNK_HDR |-> idx_q <= 5'd7) and
    (phase_q == PH_FMT_BODY |-> idx_q <= 5'd15))
    else $error("field index out of range");

endmodule

`default_nettype wire

[dv/wav_header_parser_checker.sv]
`timescale 1ns / 1ps

module wav_header_parser_checker (
  input  logic clk_i,
  input  logic rst_ni,
  wavhp_in_if  in_i,
  wavhp_out_if out_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);
  import wavhp_pkg::*;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_RIFF_TAG,
    PS_RIFF_SIZE,
    PS_WAVE_TAG,
    PS_CHUNK_HDR,
    PS_FMT_BODY,
    PS_SKIP,
    PS_DONE
  } parse_state_e;

  parse_state_e  parse_state;
  logic [4:0]    field_idx;
  logic [31:0]   tag_word;
  logic [31:0]   chunk_len;
  logic [31:0]   skip_left;
  logic [31:0]   file_pos;
  logic [15:0]   fmt_code;
  logic [15:0]   keep_ch;
  logic [31:0]   keep_rate;
  logic [15:0]   keep_bits;
  logic          fmt_good;
  wavhp_result_t next_header;
  wavhp_result_t header_q[$];

  function automatic void clear_parse();
    parse_state = PS_IDLE;
    field_idx   = '0;
    tag_word    = '0;
    chunk_len   = '0;
    skip_left   = '0;
    file_pos    = '0;
    fmt_code    = '0;
    keep_ch     = 16'd1;
    keep_rate   = '0;
    keep_bits   = 16'd16;
    fmt_good    = 1'b0;
  endfunction

  function automatic void finish_header(wavhp_status_e st, logic [31:0] off, logic [31:0] len);
    next_header.status        = st;
    next_header.channel_count = keep_ch;
    next_header.sample_rate   = keep_rate;
    next_header.sample_bits   = keep_bits;
    next_header.data_offset   = off;
    next_header.data_length   = len;
    parse_state               = PS_DONE;
  endfunction

  function automatic void leave_chunk();
    field_idx   = '0;
    parse_state = (skip_left != 0) ? PS_SKIP : PS_CHUNK_HDR;
  endfunction

  // Advance the header walk by one file byte; returns 1 when a header result is due.
  function automatic bit parse_byte(logic [7:0] b, logic mark_first, logic mark_last);
    int            idx;
    wavhp_status_e st;
    if (mark_first) begin
      clear_parse();
      parse_state = PS_RIFF_TAG;
    end
    if (parse_state == PS_IDLE || parse_state == PS_DONE) return 1'b0;
    file_pos = file_pos + 32'd1;
    idx = int'(field_idx);
    case (parse_state)
      PS_RIFF_TAG, PS_WAVE_TAG: begin
        tag_word = {tag_word[23:0], b};
        if (idx >= 3) begin
          if (tag_word != ((parse_state == PS_RIFF_TAG) ? TAG_RIFF : TAG_WAVE)) begin
            finish_header(ST_BAD_TAG, '0, '0);
            return 1'b1;
          end
          field_idx   = '0;
          parse_state = (parse_state == PS_RIFF_TAG) ? PS_RIFF_SIZE : PS_CHUNK_HDR;
        end else begin
          field_idx = field_idx + 5'd1;
        end
      end
      PS_RIFF_SIZE: begin
        if (idx >= 3) begin
          field_idx   = '0;
          parse_state = PS_WAVE_TAG;
        end else begin
          field_idx = field_idx + 5'd1;
        end
      end
      PS_CHUNK_HDR: begin
        if (idx < 4) begin
          tag_word = {tag_word[23:0], b};
          if (idx == 0) chunk_len = '0;
          field_idx = field_idx + 5'd1;
        end else begin
          chunk_len[8*(idx-4) +: 8] = b;
          if (idx < 7) begin
            field_idx = field_idx + 5'd1;
          end else if (tag_word == TAG_DATA) begin
            if (!fmt_good) st = ST_BAD_FORMAT;
            else if (chunk_len == 0) st = ST_EMPTY_DATA;
            else st = ST_OK;
            finish_header(st, file_pos, chunk_len);
            return 1'b1;
          end else if (tag_word == TAG_FMT && chunk_len >= FMT_MIN_LENGTH) begin
            skip_left   = chunk_len - FMT_MIN_LENGTH;
            field_idx   = '0;
            parse_state = PS_FMT_BODY;
          end else begin
            if (tag_word == TAG_FMT) fmt_good = 1'b0;
            skip_left = chunk_len;
            leave_chunk();
          end
        end
      end
      PS_FMT_BODY: begin
        if (idx < 2) fmt_code[8*idx +: 8] = b;
        else if (idx < 4) keep_ch[8*(idx-2) +: 8] = b;
        else if (idx < 8) keep_rate[8*(idx-4) +: 8] = b;
        else if (idx >= 14) keep_bits[8*(idx-14) +: 8] = b;
        if (idx >= 15) begin
          fmt_good = (fmt_code == FORMAT_PCM) && (keep_bits == BITS_SUPPORTED) &&
                     (keep_ch == 16'd1 || keep_ch == 16'd2);
          leave_chunk();
        end else begin
          field_idx = field_idx + 5'd1;
        end
      end
      PS_SKIP: begin
        if (skip_left != 0) skip_left = skip_left - 32'd1;
        if (skip_left == 0) begin
          field_idx   = '0;
          parse_state = PS_CHUNK_HDR;
        end
      end
      default: ;
    endcase
    if (mark_last) begin
      finish_header(ST_TRUNCATED, '0, '0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void check_header();
    wavhp_result_t want;
    wavhp_result_t got;
    got.status        = wavhp_status_e'(out_i.status);
    got.channel_count = out_i.channel_count;
    got.sample_rate   = out_i.sample_rate;
    got.sample_bits   = out_i.sample_bits;
    got.data_offset   = out_i.data_offset;
    got.data_length   = out_i.data_length;
    checked_o = checked_o + 1;
    if (header_q.size() == 0) begin
      fail_count_o = fail_count_o + 1;
      if (fail_count_o <= 10)
        $display("%0t: header beat with none pending: status %0d off %0d len %0d",
                 $time, got.status, got.data_offset, got.data_length);
    end else begin
      want = header_q.pop_front();
      if (got !== want) begin
        fail_count_o = fail_count_o + 1;
        if (fail_count_o <= 10) begin
          $display("%0t: header mismatch", $time);
          $display("  expected status %0d ch %0d rate %0d bits %0d off %0d len %0d",
                   want.status, want.channel_count, want.sample_rate, want.sample_bits,
                   want.data_offset, want.data_length);
          $display("  actual   status %0d ch %0d rate %0d bits %0d off %0d len %0d",
                   got.status, got.channel_count, got.sample_rate, got.sample_bits,
                   got.data_offset, got.data_length);
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      header_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (out_i.valid && out_i.ready) check_header();
      if (in_i.valid && in_i.ready) begin
        if (parse_byte(in_i.data_byte, in_i.first_byte, in_i.last_byte))
          header_q.push_back(next_header);
      end
      pending_o = header_q.size();
    end
  end

endmodule

[dv/wav_header_parser_top_test.sv]
`timescale 1ns / 1ps

module wav_header_parser_top_test;
  import wavhp_pkg::*;

  localparam int IdleLimit  = 500;
  localparam int ByteTarget = 1550;

  logic clk_i;
  logic rst_ni;

  wavhp_in_if  byte_ch ();
  wavhp_out_if header_ch ();

  int         fail_count;
  int         pending_headers;
  int         headers_checked;
  int         idle_cycles;
  int         files_sent;
  int         bytes_sent;
  bit         calm;
  logic [7:0] file_bytes[$];

  wav_header_parser_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch.sink),
    .out_o  (header_ch.source)
  );

  wav_header_parser_checker header_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (byte_ch),
    .out_i        (header_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_headers),
    .checked_o    (headers_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (byte_ch.valid && byte_ch.ready) || (header_ch.valid && header_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("wav_header_parser_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic void put_le(logic [31:0] v, int nbytes);
    for (int k = 0; k < nbytes; k++) file_bytes.push_back(v[8*k +: 8]);
  endfunction

  function automatic void put_tag(logic [31:0] tag);
    for (int k = 3; k >= 0; k--) file_bytes.push_back(tag[8*k +: 8]);
  endfunction

  function automatic void put_filler(int n);
    for (int k = 0; k < n; k++) file_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_head();
    put_tag(TAG_RIFF);
    put_le($urandom, 4);
    put_tag(TAG_WAVE);
  endfunction

  function automatic void put_fmt(logic [15:0] code, logic [15:0] chans, logic [31:0] rate,
                                  logic [15:0] bits, int extra);
    put_tag(TAG_FMT);
    put_le(32'd16 + 32'(extra), 4);
    put_le(32'(code), 2);
    put_le(32'(chans), 2);
    put_le(rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le(32'(bits), 2);
    put_filler(extra);
  endfunction

  function automatic void put_chunk(logic [31:0] tag, int len);
    put_tag(tag);
    put_le(32'(len), 4);
    put_filler(len);
  endfunction

  function automatic void put_data(logic [31:0] len, int samples);
    put_tag(TAG_DATA);
    put_le(len, 4);
    put_filler(samples);
  endfunction

  // Unknown chunk tag: either random or one byte off from fmt/data.
  function automatic logic [31:0] near_tag();
    logic [31:0] tag;
    if ($urandom_range(0, 1) == 0) return $urandom;
    tag = ($urandom_range(0, 1) == 0) ? TAG_FMT : TAG_DATA;
    tag[8*$urandom_range(0, 3) +: 8] ^= 8'($urandom_range(1, 255));
    return tag;
  endfunction

  function automatic void build_random_file();
    logic [31:0] len;
    int          roll;
    put_head();
    if ($urandom_range(0, 2) == 0) put_chunk(near_tag(), $urandom_range(0, 6));
    if ($urandom_range(0, 3) != 0)
      put_fmt(FORMAT_PCM, 16'($urandom_range(1, 2)), $urandom, BITS_SUPPORTED,
              ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4));
    else
      put_fmt(16'($urandom_range(0, 2)), ($urandom_range(0, 3) == 0) ? 16'($urandom) :
              16'($urandom_range(0, 3)), $urandom,
              ($urandom_range(0, 1) == 0) ? BITS_SUPPORTED : 16'($urandom),
              $urandom_range(0, 4));
    case ($urandom_range(0, 5))
      0:       put_chunk(TAG_FMT, $urandom_range(0, 15));
      1:       put_chunk(near_tag(), $urandom_range(0, 6));
      2:       put_fmt(FORMAT_PCM, 16'($urandom_range(0, 3)), $urandom,
                       BITS_SUPPORTED, 0);
      default: ;
    endcase
    roll = $urandom_range(0, 9);
    if (roll == 0) len = '0;
    else if (roll == 1) len = 32'hFFFF_FFFF;
    else len = $urandom;
    put_data(len, $urandom_range(0, 3));
  endfunction

  task automatic send_byte(logic [7:0] value, logic mark_first, logic mark_last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.data_byte  <= value;
    byte_ch.first_byte <= mark_first;
    byte_ch.last_byte  <= mark_last;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_file(bit with_first, int last_at);
    calm = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], with_first && i == 0, i == last_at);
    if (with_first) bytes_sent += file_bytes.size();
    files_sent++;
    file_bytes.delete();
  endtask

  task automatic drain_headers();
    byte_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending_headers != 0);
    @(posedge clk_i);
  endtask

  initial begin
    int stall;
    header_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        header_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      header_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!header_ch.valid) @(posedge clk_i);
    end
  end

  initial begin
    int          roll;
    int          last_at;
    int          pick;
    logic [15:0] bad_code[4];
    logic [15:0] bad_ch[4];
    logic [15:0] bad_bits[4];
    rst_ni             = 1'b0;
    byte_ch.valid      <= 1'b0;
    byte_ch.data_byte  <= '0;
    byte_ch.first_byte <= 1'b0;
    byte_ch.last_byte  <= 1'b0;
    calm               = 1'b0;
    files_sent         = 0;
    bytes_sent         = 0;
    bad_code = '{FORMAT_PCM, FORMAT_PCM, FORMAT_PCM, 16'hFFFF};
    bad_ch   = '{16'd0, 16'd3, 16'd2, 16'd1};
    bad_bits = '{BITS_SUPPORTED, BITS_SUPPORTED, 16'd8, BITS_SUPPORTED};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // drop: bytes before any first byte
    put_filler(3);
    send_file(1'b0, 2);
    put_head();
    put_fmt(FORMAT_PCM, 16'd2, 32'd44100, BITS_SUPPORTED, 0);
    put_data(32'd1000, 4);
    send_file(1'b1, file_bytes.size() - 1);
    // extreme fields, trailing bytes after the result
    put_head();
    put_fmt(FORMAT_PCM, 16'd1, 32'hFFFF_FFFF, BITS_SUPPORTED, 0);
    put_data(32'hFFFF_FFFF, 0);
    put_filler(3);
    send_file(1'b1, file_bytes.size() - 1);
    put_tag(TAG_RIFF ^ 32'h0000_0001);
    send_file(1'b1, 3);
    put_tag(TAG_RIFF);
    put_le($urandom, 4);
    put_tag(TAG_WAVE ^ 32'h0100_0000);
    send_file(1'b1, file_bytes.size() - 1);
    put_head();
    put_fmt(FORMAT_PCM, 16'd2, 32'd48000, BITS_SUPPORTED, 0);
    send_file(1'b1, 20);
    put_head();
    put_fmt(FORMAT_PCM, 16'd1, 32'd8000, BITS_SUPPORTED, 0);
    put_data(32'd2, 0);
    send_file(1'b1, file_bytes.size() - 1);
    put_head();
    put_data(32'd5, 1);
    send_file(1'b1, file_bytes.size() - 1);
    put_head();
    put_fmt(FORMAT_PCM, 16'd2, 32'd22050, BITS_SUPPORTED, 0);
    put_chunk(TAG_FMT, 8);
    put_data(32'd16, 0);
    send_file(1'b1, file_bytes.size() - 1);
    put_head();
    put_fmt(FORMAT_PCM, 16'd2, 32'd96000, BITS_SUPPORTED, 5);
    put_chunk(32'h4C49_5354, 0);
    put_chunk(TAG_FMT ^ 32'h0000_0001, 3);
    put_chunk(TAG_DATA ^ 32'h0000_0100, 2);
    put_data(32'd0, 0);
    send_file(1'b1, file_bytes.size() - 1);
    put_head();
    put_fmt(16'd3, 16'd2, 32'd44100, 16'd32, 0);
    put_fmt(FORMAT_PCM, 16'd2, 32'd11025, BITS_SUPPORTED, 0);
    put_data(32'd7, 0);
    send_file(1'b1, file_bytes.size() - 1);
    for (int v = 0; v < 4; v++) begin
      put_head();
      put_fmt(bad_code[v], bad_ch[v], $urandom, bad_bits[v], 0);
      put_data((v == 0) ? 32'd0 : 32'd4, 0);
      send_file(1'b1, file_bytes.size() - 1);
    end
    // drop: restart in the middle of a parse
    put_head();
    put_filler(5);
    send_file(1'b1, -1);
    put_head();
    put_fmt(FORMAT_PCM, 16'd1, 32'd16000, BITS_SUPPORTED, 0);
    put_data(32'd64, 2);
    send_file(1'b1, file_bytes.size() - 1);

    // hold input until every pending header has come out
    drain_headers();

    while (bytes_sent < ByteTarget) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 10))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0,
                    $urandom_range(0, 3) == 0);
      end else begin
        build_random_file();
        if ($urandom_range(0, 6) == 0) begin
          pick = $urandom_range(0, file_bytes.size() - 1);
          file_bytes[pick] = file_bytes[pick] ^ 8'($urandom_range(1, 255));
        end
        roll = $urandom_range(0, 19);
        if (roll < 3) last_at = $urandom_range(0, file_bytes.size() - 1);
        else if (roll < 5) last_at = -1;
        else last_at = file_bytes.size() - 1;
        if ($urandom_range(0, 4) == 0) put_filler($urandom_range(1, 4));
        send_file($urandom_range(0, 19) != 0, last_at);
      end
    end

    drain_headers();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d parsed file bytes in %0d files plus noise; %0d headers checked.",
             bytes_sent, files_sent, headers_checked);
    $display("Covered bad tags, truncation, short/long/unsupported fmt, empty data, restarts.");
    if (fail_count == 0) begin
      $display("wav_header_parser_top regression: pass");
    end else begin
      $display("wav_header_parser_top regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/wavhp_pkg.sv
hw/rtl/wavhp_if.sv
hw/rtl/wavhp_core.sv
hw/rtl/wav_header_parser_top.sv
dv/wav_header_parser_checker.sv
dv/wav_header_parser_top_test.sv
